### sv/ntf_pkg.sv
// ----------------------------------------------------------------------------
// ntf_pkg: shared types and constants for the number-to-text formatter
// Format codes, controller states, ASCII constants and the per-cycle helper
// functions for bit-serial binary-to-BCD conversion and digit glyph lookup.
// ----------------------------------------------------------------------------
package ntf_pkg;

    localparam int VALUE_W    = 32;
    localparam int COLOR_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int OP_W       = 2;
    localparam int NUM_DEC    = 10;            // decimal digits of a 32-bit value
    localparam int NUM_HEX    = 8;             // hex digits of a 32-bit value
    localparam int DIG_W      = 4 * NUM_DEC;   // digit shift register width
    localparam int CNT_W      = 4;             // holds 1..NUM_DEC
    localparam int BIT_CNT_W  = 5;             // indexes the 32 value bits

    localparam logic [OP_W-1:0] OP_UDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_SDEC = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;  // 'x'

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_HEX0,
        ST_HEXX,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // One double-dabble step: correct each BCD digit, then shift in the next bit.
    function automatic logic [DIG_W-1:0] dabble_step(input logic [DIG_W-1:0] d,
                                                    input logic b);
        logic [DIG_W-1:0] t;
        t = d;
        for (int i = 0; i < NUM_DEC; i++) begin
            if (t[4*i +: 4] >= 4'd5) begin
                t[4*i +: 4] = t[4*i +: 4] + 4'd3;
            end
        end
        return {t[DIG_W-2:0], b};
    endfunction

    // Uppercase hex / decimal glyph for one digit.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] g;
        if (d < 4'd10) begin
            g = CHAR_ZERO + {4'd0, d};
        end
        else begin
            g = CHAR_UPPER + {4'd0, d - 4'd10};
        end
        return g;
    endfunction

endpackage

### sv/number_to_text_formatter.sv
// ----------------------------------------------------------------------------
// number_to_text_formatter: 32-bit value to a run of ASCII text cells
// Bit-serial binary-to-decimal conversion and serial digit emission.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tdata holds value and color, tuser the format
//   (unsigned decimal, signed decimal, or hex with a "0x" prefix).
//   m_axis returns one text cell per item: tdata holds the ASCII character
//   and the attribute byte, tlast marks the final cell of a run.
//   Runs hold 1 to 11 cells, most significant character first.
// Sequence:
//   Decimal formats shift the value through a double-dabble BCD register one
//   bit per cycle. Hex skips that pass. Leading zero digits are then
//   dropped at one per cycle, the controller enters emission, and each
//   remaining digit passes through the output register. s_axis_tready is
//   high only between runs.
// Reset and stall:
//   rst_n clears the controller and the output valid flag. When the receiver
//   holds m_axis_tready low the current cell stays in the output register
//   and the controller waits before loading the next cell.
// ----------------------------------------------------------------------------
module number_to_text_formatter
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [39:32] color
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] character, [15:8] attribute
    output logic        m_axis_tlast
);

    ntf_pkg::state_t state_reg, state_next;

    logic [ntf_pkg::VALUE_W-1:0]   bin_reg,   bin_next;
    logic [ntf_pkg::DIG_W-1:0]     dig_reg,   dig_next;
    logic [ntf_pkg::CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [ntf_pkg::BIT_CNT_W-1:0] bit_reg,   bit_next;
    logic                          neg_reg,   neg_next;
    logic [ntf_pkg::COLOR_W-1:0]   color_reg, color_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ntf_pkg::CHAR_W-1:0]    out_char_reg,  out_char_next;
    logic [ntf_pkg::COLOR_W-1:0]   out_attr_reg,  out_attr_next;
    logic                          out_last_reg,  out_last_next;

    logic                          out_free;
    logic                          in_accept;
    logic [ntf_pkg::VALUE_W-1:0]   in_value;
    logic                          in_neg;
    logic [3:0]                    top_digit;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_value  = s_axis_tdata[ntf_pkg::VALUE_W-1:0];
    assign in_neg    = (s_axis_tuser == ntf_pkg::OP_SDEC) && in_value[ntf_pkg::VALUE_W-1];
    assign top_digit = dig_reg[ntf_pkg::DIG_W-1 -: 4];

    assign s_axis_tready = (state_reg == ntf_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_attr_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        dig_reg      <= dig_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        neg_reg      <= neg_next;
        color_reg    <= color_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        bit_next       = bit_reg;
        neg_next       = neg_reg;
        color_next     = color_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ntf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    color_next = s_axis_tdata[ntf_pkg::VALUE_W +: ntf_pkg::COLOR_W];
                    neg_next   = in_neg;
                    bit_next   = ntf_pkg::BIT_CNT_W'(ntf_pkg::VALUE_W - 1);
                    if (s_axis_tuser == ntf_pkg::OP_HEX)
                    begin
                        // Hex digits are the value's nibbles; load them at the top.
                        dig_next   = {in_value, {(ntf_pkg::DIG_W - ntf_pkg::VALUE_W){1'b0}}};
                        cnt_next   = ntf_pkg::CNT_W'(ntf_pkg::NUM_HEX);
                        state_next = ntf_pkg::ST_HEX0;
                    end
                    else
                    begin
                        bin_next   = in_neg ? (~in_value + ntf_pkg::VALUE_W'(1)) : in_value;
                        dig_next   = '0;
                        cnt_next   = ntf_pkg::CNT_W'(ntf_pkg::NUM_DEC);
                        state_next = ntf_pkg::ST_CONV;
                    end
                end
            end

            ntf_pkg::ST_CONV:
            begin
                dig_next = ntf_pkg::dabble_step(dig_reg, bin_reg[ntf_pkg::VALUE_W-1]);
                bin_next = {bin_reg[ntf_pkg::VALUE_W-2:0], 1'b0};
                bit_next = bit_reg - ntf_pkg::BIT_CNT_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = neg_reg ? ntf_pkg::ST_SIGN : ntf_pkg::ST_SKIP;
                end
            end

            ntf_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ntf_pkg::CHAR_MINUS;
                    out_attr_next  = color_reg;
                    out_last_next  = 1'b0;
                    state_next     = ntf_pkg::ST_SKIP;
                end
            end

            ntf_pkg::ST_HEX0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ntf_pkg::CHAR_ZERO;
                    out_attr_next  = color_reg;
                    out_last_next  = 1'b0;
                    state_next     = ntf_pkg::ST_HEXX;
                end
            end

            ntf_pkg::ST_HEXX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ntf_pkg::CHAR_X;
                    out_attr_next  = color_reg;
                    out_last_next  = 1'b0;
                    state_next     = ntf_pkg::ST_SKIP;
                end
            end

            ntf_pkg::ST_SKIP:
            begin
                // Drop leading zero digits, keeping at least one.
                if (top_digit == 4'd0 && cnt_reg != ntf_pkg::CNT_W'(1))
                begin
                    dig_next = {dig_reg[ntf_pkg::DIG_W-5:0], 4'd0};
                    cnt_next = cnt_reg - ntf_pkg::CNT_W'(1);
                end
                else
                begin
                    state_next = ntf_pkg::ST_EMIT;
                end
            end

            ntf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ntf_pkg::digit_glyph(top_digit);
                    out_attr_next  = color_reg;
                    out_last_next  = (cnt_reg == ntf_pkg::CNT_W'(1));
                    dig_next       = {dig_reg[ntf_pkg::DIG_W-5:0], 4'd0};
                    cnt_next       = cnt_reg - ntf_pkg::CNT_W'(1);
                    if (cnt_reg == ntf_pkg::CNT_W'(1))
                    begin
                        state_next = ntf_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ntf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
